// ===== src/mh2_pkg.sv =====
// shared constants, types and helper functions of the meshhash2 engine
package mh2_pkg;

  localparam int MAX_LANES        = 33;
  localparam int MAX_DIGEST_BYTES = 256;
  localparam int LANE_DEPTH       = MAX_LANES + 1;
  localparam int FB_DEPTH         = 2 * MAX_LANES;
  localparam int LANE_AW          = $clog2(LANE_DEPTH);
  localparam int FB_AW            = $clog2(FB_DEPTH);

  localparam logic [63:0] MUL_K = 64'h9e3779b97f4a7bb9;
  localparam logic [63:0] ADD_K = 64'h5e2d58d8b3bcdef7;
  localparam logic [5:0]  SBOX_ROT = 6'd37;
  localparam logic [5:0]  LANE_ROT = 6'd37;

  typedef logic [2:0] op_t;
  localparam op_t OP_NORMAL = 3'd0;
  localparam op_t OP_BLOCK  = 3'd1;
  localparam op_t OP_MIX    = 3'd2;
  localparam op_t OP_XOR    = 3'd3;
  localparam op_t OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [63:0] data;
  } cmd_t;

  typedef struct packed {
    logic               done;
    logic [LANE_AW-1:0] round_index;
    logic [7:0]         xor_byte;
  } stat_t;

  function automatic logic [63:0] rotr64(input logic [63:0] w, input logic [5:0] b);
    rotr64 = (w >> b) | (w << (7'd64 - {1'b0, b}));
  endfunction

endpackage

// ===== src/mh2_if.sv =====
// stream interfaces of the meshhash2 engine: message bytes, digest words, configuration
interface mh2_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [3:0] bit_count;
  logic       last;
  modport source (output valid, output data_byte, output bit_count, output last, input ready);
  modport sink (input valid, input data_byte, input bit_count, input last, output ready);
endinterface

interface mh2_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_word;
  logic [3:0]  byte_count;
  logic        final_word;
  modport source (output valid, output hash_word, output byte_count, output final_word,
                  input ready);
  modport sink (input valid, input hash_word, input byte_count, input final_word,
                output ready);
endinterface

interface mh2_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] hash_bytes;
  modport source (output valid, output hash_bytes, input ready);
  modport sink (input valid, input hash_bytes, output ready);
endinterface

// ===== src/mh2_ram.sv =====
// generic simple dual-port ram with registered read
module mh2_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 34
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mh2_sbox.sv =====
// iterative s-box: two rounds of multiply, add and rotate over one 32x32 multiplier
module mh2_sbox
  import mh2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [63:0] y
);

  logic [2:0]  step_r, step_nxt;
  logic        half_r, half_nxt;
  logic        done_r, done_nxt;
  logic [63:0] w_r, w_nxt;
  logic [63:0] p_r, p_nxt;
  logic [31:0] m_r, m_nxt;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, sum;

  always_comb begin
    mul_a = (step_r == 3'd3) ? w_r[63:32] : w_r[31:0];
    mul_b = (step_r == 3'd2) ? MUL_K[63:32] : MUL_K[31:0];
    prod  = 64'(mul_a) * 64'(mul_b);
    sum   = p_r + {m_r, 32'h0} + ADD_K;
  end

  always_comb begin
    step_nxt = step_r;
    half_nxt = half_r;
    done_nxt = 1'b0;
    w_nxt    = w_r;
    p_nxt    = p_r;
    m_nxt    = m_r;
    if (start) begin
      w_nxt    = x;
      step_nxt = 3'd1;
      half_nxt = 1'b0;
    end else begin
      unique case (step_r)
        3'd1: begin
          p_nxt    = prod;
          step_nxt = 3'd2;
        end
        3'd2: begin
          m_nxt    = prod[31:0];
          step_nxt = 3'd3;
        end
        3'd3: begin
          m_nxt    = m_r + prod[31:0];
          step_nxt = 3'd4;
        end
        3'd4: begin
          w_nxt = rotr64(sum, SBOX_ROT);
          if (half_r) begin
            step_nxt = 3'd0;
            done_nxt = 1'b1;
          end else begin
            half_nxt = 1'b1;
            step_nxt = 3'd1;
          end
        end
        default: step_nxt = step_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
      half_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      half_r <= half_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    p_r <= p_nxt;
    m_r <= m_nxt;
  end

  assign done = done_r;
  assign y    = w_r;

endmodule

// ===== src/mh2_engine.sv =====
// lane engine: lane and feedback memories, read-modify-write passes over all lanes
module mh2_engine
  import mh2_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [LANE_AW-1:0] lanes,
  input  logic [11:0]        digest_bits,
  input  logic [3:0][63:0]   msg_bits,
  output stat_t              stat
);

  localparam logic [3:0] E_IDLE  = 4'd0;
  localparam logic [3:0] E_PRE1  = 4'd1;
  localparam logic [3:0] E_RD    = 4'd2;
  localparam logic [3:0] E_GET   = 4'd3;
  localparam logic [3:0] E_GET2  = 4'd4;
  localparam logic [3:0] E_SBS   = 4'd5;
  localparam logic [3:0] E_SBW   = 4'd6;
  localparam logic [3:0] E_POST0 = 4'd7;
  localparam logic [3:0] E_POST1 = 4'd8;
  localparam logic [3:0] E_CLR   = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic [LANE_AW-1:0] i_r, i_nxt;
  logic [2:0]         s_r, s_nxt;
  op_t                op_r, op_nxt;
  logic [63:0]        data_r, data_nxt;
  logic [63:0]        cur_r, cur_nxt;
  logic [63:0]        nx_r, nx_nxt;
  logic [63:0]        fa_r, fa_nxt;
  logic [63:0]        fb2_r, fb2_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [7:0]         xacc_r, xacc_nxt;
  logic [LANE_AW-1:0] ri_r, ri_nxt;
  logic [3:0][63:0]   bc_r, bc_nxt;
  logic [FB_AW-1:0]   clr_r, clr_nxt;
  logic               done_r, done_nxt;

  logic               l_we;
  logic [LANE_AW-1:0] l_waddr, l_raddr;
  logic [63:0]        l_wdata, l_rdata;
  logic               f_we;
  logic [FB_AW-1:0]   f_waddr, f_raddr;
  logic [63:0]        f_wdata, f_rdata;

  logic               sb_start, sb_done;
  logic [63:0]        sb_x, sb_y;
  logic [63:0]        lane_k, op_val;
  logic [2:0]         s_last;
  logic               lane_fin, finish;
  logic [LANE_AW-1:0] ri_inc;

  function automatic logic [FB_AW-1:0] fb_addr(input logic bank, input logic [LANE_AW-1:0] idx);
    fb_addr = bank ? FB_AW'(MAX_LANES) + FB_AW'(idx) : FB_AW'(idx);
  endfunction

  mh2_ram #(.WIDTH(64), .DEPTH(LANE_DEPTH)) u_lane_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata)
  );

  mh2_ram #(.WIDTH(64), .DEPTH(FB_DEPTH)) u_fb_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );

  mh2_sbox u_sbox (
    .clk(clk), .rst_n(rst_n), .start(sb_start), .x(sb_x), .done(sb_done), .y(sb_y)
  );

  always_comb begin
    lane_k = {8{2'b00, i_r}};
    ri_inc = (ri_r < LANE_AW'(63)) ? LANE_AW'(ri_r + 1'b1) : ri_r;
    unique case (op_r)
      OP_BLOCK: s_last = 3'd2;
      OP_MIX:   s_last = 3'd4;
      default:  s_last = 3'd0;
    endcase
    unique case (op_r)
      OP_BLOCK: begin
        if (s_r == 3'd0) begin
          op_val = bc_r[i_r[1:0]];
        end else if (s_r == 3'd1) begin
          op_val = fa_r;
        end else begin
          op_val = fb2_r;
        end
      end
      OP_MIX: begin
        if (s_r < 3'd4) begin
          op_val = msg_bits[s_r[1:0]] ^ lane_k;
        end else begin
          op_val = 64'(digest_bits) ^ lane_k;
        end
      end
      default: op_val = 64'h0;
    endcase
    sb_x = acc_r ^ op_val;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    s_nxt     = s_r;
    op_nxt    = op_r;
    data_nxt  = data_r;
    cur_nxt   = cur_r;
    nx_nxt    = nx_r;
    fa_nxt    = fa_r;
    fb2_nxt   = fb2_r;
    acc_nxt   = acc_r;
    xacc_nxt  = xacc_r;
    ri_nxt    = ri_r;
    bc_nxt    = bc_r;
    clr_nxt   = clr_r;
    done_nxt  = 1'b0;
    lane_fin  = 1'b0;
    finish    = 1'b0;
    l_we      = 1'b0;
    l_waddr   = i_r;
    l_wdata   = 64'h0;
    l_raddr   = i_r;
    f_we      = 1'b0;
    f_waddr   = clr_r;
    f_wdata   = 64'h0;
    f_raddr   = fb_addr(1'b0, i_r);
    sb_start  = 1'b0;
    unique case (state_r)
      E_IDLE: begin
        if (cmd.start) begin
          op_nxt   = cmd.op;
          data_nxt = cmd.data;
          i_nxt    = '0;
          xacc_nxt = 8'h0;
          clr_nxt  = '0;
          unique case (cmd.op)
            OP_NORMAL: begin
              l_raddr   = '0;
              state_nxt = E_PRE1;
            end
            OP_CLEAR: state_nxt = E_CLR;
            default:  state_nxt = E_RD;
          endcase
        end
      end
      E_PRE1: begin
        // copy of lane zero sits one past the last lane
        l_we      = 1'b1;
        l_waddr   = lanes;
        l_wdata   = l_rdata;
        state_nxt = E_RD;
      end
      E_RD: begin
        l_raddr   = i_r;
        f_raddr   = fb_addr(~bc_r[0][0], i_r);
        state_nxt = E_GET;
      end
      E_GET: begin
        cur_nxt   = l_rdata;
        fa_nxt    = f_rdata;
        l_raddr   = LANE_AW'(i_r + 1'b1);
        f_raddr   = fb_addr(bc_r[0][0], i_r);
        state_nxt = E_GET2;
      end
      E_GET2: begin
        nx_nxt  = l_rdata;
        fb2_nxt = f_rdata;
        s_nxt   = 3'd0;
        if (op_r == OP_NORMAL) begin
          acc_nxt = rotr64(cur_r ^ lane_k ^ data_r, 6'(i_r * LANE_ROT));
        end else begin
          acc_nxt = cur_r;
        end
        if (op_r == OP_XOR) begin
          if (!i_r[0]) begin
            xacc_nxt = xacc_r ^ cur_r[7:0];
          end
          lane_fin = 1'b1;
        end else begin
          state_nxt = E_SBS;
        end
      end
      E_SBS: begin
        sb_start  = 1'b1;
        state_nxt = E_SBW;
      end
      E_SBW: begin
        if (sb_done) begin
          if (s_r == s_last) begin
            l_we     = 1'b1;
            l_waddr  = i_r;
            l_wdata  = (op_r == OP_NORMAL) ? sb_y + nx_r : sb_y;
            lane_fin = 1'b1;
          end else begin
            acc_nxt   = sb_y;
            s_nxt     = s_r + 3'd1;
            state_nxt = E_SBS;
          end
        end
      end
      E_POST0: begin
        if (ri_r < LANE_AW'(MAX_LANES)) begin
          l_raddr   = ri_r;
          state_nxt = E_POST1;
        end else begin
          ri_nxt = ri_inc;
          finish = 1'b1;
        end
      end
      E_POST1: begin
        f_we    = 1'b1;
        f_waddr = fb_addr(bc_r[0][0], ri_r);
        f_wdata = l_rdata;
        ri_nxt  = ri_inc;
        finish  = 1'b1;
      end
      E_CLR: begin
        l_we    = (clr_r < FB_AW'(LANE_DEPTH));
        l_waddr = clr_r[LANE_AW-1:0];
        f_we    = 1'b1;
        f_waddr = clr_r;
        clr_nxt = FB_AW'(clr_r + 1'b1);
        if (clr_r == FB_AW'(FB_DEPTH - 1)) begin
          bc_nxt = '0;
          ri_nxt = '0;
          finish = 1'b1;
        end
      end
      default: state_nxt = E_IDLE;
    endcase

    if (lane_fin) begin
      if (LANE_AW'(i_r + 1'b1) == lanes) begin
        unique case (op_r)
          OP_NORMAL: state_nxt = E_POST0;
          OP_BLOCK: begin
            bc_nxt = bc_r + 256'd1;
            ri_nxt = '0;
            finish = 1'b1;
          end
          default: finish = 1'b1;
        endcase
      end else begin
        i_nxt     = LANE_AW'(i_r + 1'b1);
        state_nxt = E_RD;
      end
    end
    if (finish) begin
      state_nxt = E_IDLE;
      done_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      ri_r    <= '0;
      bc_r    <= '0;
      done_r  <= 1'b0;
      i_r     <= '0;
      s_r     <= 3'd0;
      op_r    <= OP_NORMAL;
      clr_r   <= '0;
      xacc_r  <= 8'h0;
    end else begin
      state_r <= state_nxt;
      ri_r    <= ri_nxt;
      bc_r    <= bc_nxt;
      done_r  <= done_nxt;
      i_r     <= i_nxt;
      s_r     <= s_nxt;
      op_r    <= op_nxt;
      clr_r   <= clr_nxt;
      xacc_r  <= xacc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    cur_r  <= cur_nxt;
    nx_r   <= nx_nxt;
    fa_r   <= fa_nxt;
    fb2_r  <= fb2_nxt;
    acc_r  <= acc_nxt;
  end

  assign stat.done        = done_r;
  assign stat.round_index = ri_r;
  assign stat.xor_byte    = xacc_r;

endmodule

// ===== src/meshhash2_hash_engine.sv =====
// meshhash2 hash engine top level: byte packing, round sequencing and digest output
// Usage:
// in_ch carries one message byte per word, most significant bit first, with
// bit_count valid leading bits and last on the final byte of a message.
// out_ch returns the digest as 64-bit words, first byte high, byte_count valid
// bytes each, final_word on the last one. cfg_ch writes hash_bytes; write it
// only between messages.
// Operation: a byte that does not complete a 64-bit word is packed into the word
// buffer. A full word runs a round over the n lanes (n = ceil(hash_bytes/8)+1,
// hash_bytes capped at 256, n at least 4) through one shared iterative s-box;
// after n rounds a block round follows. The last byte runs finalization and then
// one round and one xor pass per digest byte.
// in_ch.ready is high only while the engine waits for a byte.
// A stalled out_ch holds the sequencer at the next digest word; the final word
// may stay pending while the next message is taken.
// After reset and after each digest a clearing pass zeroes the
// lane and feedback memories; no byte is taken during it.
module meshhash2_hash_engine
  import mh2_pkg::*;
(
  input logic clk,
  input logic rst_n,
  mh2_in_if.sink    in_ch,
  mh2_out_if.source out_ch,
  mh2_cfg_if.sink   cfg_ch
);

  localparam logic [3:0] T_IDLE = 4'd0;
  localparam logic [3:0] T_RND  = 4'd1;
  localparam logic [3:0] T_RCHK = 4'd2;
  localparam logic [3:0] T_RBLK = 4'd3;
  localparam logic [3:0] T_F1   = 4'd4;
  localparam logic [3:0] T_F2   = 4'd5;
  localparam logic [3:0] T_F2B  = 4'd6;
  localparam logic [3:0] T_F3   = 4'd7;
  localparam logic [3:0] T_F4   = 4'd8;
  localparam logic [3:0] T_F5   = 4'd9;
  localparam logic [3:0] T_SQN  = 4'd10;
  localparam logic [3:0] T_SQX  = 4'd11;
  localparam logic [3:0] T_SQE  = 4'd12;
  localparam logic [3:0] T_SQC  = 4'd13;
  localparam logic [3:0] T_SQB  = 4'd14;
  localparam logic [3:0] T_CLR  = 4'd15;

  logic [3:0]         state_r, state_nxt;
  logic               issued_r, issued_nxt;
  logic [8:0]         hb_r, hb_nxt;
  logic [3:0][63:0]   mb_r, mb_nxt;
  logic [63:0]        wb_r, wb_nxt;
  logic [3:0]         bb_r, bb_nxt;
  logic               last_r, last_nxt;
  logic [63:0]        rdata_r, rdata_nxt;
  logic [LANE_AW-1:0] cnt_r, cnt_nxt;
  logic [8:0]         bi_r, bi_nxt;
  logic [63:0]        word_r, word_nxt;
  logic [3:0]         inword_r, inword_nxt;
  logic               ov_r, ov_nxt;
  logic [63:0]        ow_r, ow_nxt;
  logic [3:0]         oc_r, oc_nxt;
  logic               of_r, of_nxt;

  cmd_t               cmd;
  stat_t              stat;
  logic [8:0]         eff;
  logic [LANE_AW-1:0] lanes;
  logic [3:0]         bits;
  logic [7:0]         bval;
  logic [63:0]        wbn;
  logic [3:0]         bbn;
  logic               in_acc, run_done, slot_free, full, ri_over;

  mh2_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .lanes(lanes), .digest_bits({eff, 3'b000}),
    .msg_bits(mb_r), .stat(stat)
  );

  always_comb begin
    if (hb_r == 9'd0) begin
      eff = 9'd1;
    end else if (hb_r > 9'(MAX_DIGEST_BYTES)) begin
      eff = 9'(MAX_DIGEST_BYTES);
    end else begin
      eff = hb_r;
    end
    lanes = LANE_AW'((10'(eff) + 10'd7) >> 3) + LANE_AW'(1);
    if (lanes < LANE_AW'(4)) begin
      lanes = LANE_AW'(4);
    end
    bits      = (in_ch.bit_count > 4'd8) ? 4'd8 : in_ch.bit_count;
    bval      = in_ch.data_byte & (8'hff << (4'd8 - bits));
    wbn       = {wb_r[55:0], bval};
    bbn       = bb_r + 4'd1;
    in_acc    = in_ch.valid && (state_r == T_IDLE);
    run_done  = issued_r && stat.done;
    slot_free = !ov_r || out_ch.ready;
    full      = (inword_r == 4'd8) || (bi_r == eff);
    ri_over   = (stat.round_index >= lanes);
  end

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    hb_nxt     = hb_r;
    mb_nxt     = mb_r;
    wb_nxt     = wb_r;
    bb_nxt     = bb_r;
    last_nxt   = last_r;
    rdata_nxt  = rdata_r;
    cnt_nxt    = cnt_r;
    bi_nxt     = bi_r;
    word_nxt   = word_r;
    inword_nxt = inword_r;
    ow_nxt     = ow_r;
    oc_nxt     = oc_r;
    of_nxt     = of_r;
    ov_nxt     = (ov_r && !out_ch.ready);
    cmd.start  = 1'b0;
    cmd.op     = OP_NORMAL;
    cmd.data   = 64'h0;

    if (cfg_ch.valid) begin
      hb_nxt = cfg_ch.hash_bytes;
    end

    // a run state issues each engine pass once and clears issued when the pass reports done
    unique case (state_r)
      T_RND, T_RBLK, T_F1, T_F2, T_F2B, T_F3, T_F4, T_F5, T_SQN, T_SQX, T_SQB, T_CLR: begin
        issued_nxt = !run_done;
      end
      default: issued_nxt = 1'b0;
    endcase

    unique case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          last_nxt = in_ch.last;
          if (bits != 4'd0) begin
            mb_nxt = mb_r + 256'(bits);
          end
          if ((bits != 4'd0) && (bbn == 4'd8)) begin
            rdata_nxt = wbn;
            wb_nxt    = 64'h0;
            bb_nxt    = 4'd0;
            state_nxt = T_RND;
          end else begin
            if (bits != 4'd0) begin
              wb_nxt = wbn;
              bb_nxt = bbn;
            end
            if (in_ch.last) begin
              state_nxt = T_F1;
            end
          end
        end
      end
      T_RND: begin
        cmd.start = !issued_r;
        cmd.data  = rdata_r;
        if (run_done) begin
          state_nxt = T_RCHK;
        end
      end
      T_RCHK: begin
        if (ri_over) begin
          state_nxt = T_RBLK;
        end else begin
          state_nxt = last_r ? T_F1 : T_IDLE;
        end
      end
      T_RBLK: begin
        cmd.start = !issued_r;
        cmd.op    = OP_BLOCK;
        if (run_done) begin
          state_nxt = last_r ? T_F1 : T_IDLE;
        end
      end
      T_F1: begin
        // pad the partial word, bytes left aligned
        if (bb_r == 4'd0) begin
          issued_nxt = 1'b0;
          state_nxt  = T_F2;
        end else begin
          cmd.start = !issued_r;
          cmd.data  = wb_r << {(4'd8 - bb_r), 3'b000};
          if (run_done) begin
            bb_nxt    = 4'd0;
            wb_nxt    = 64'h0;
            state_nxt = T_F2;
          end
        end
      end
      T_F2: begin
        cnt_nxt = '0;
        if (stat.round_index == '0) begin
          issued_nxt = 1'b0;
          state_nxt  = T_F3;
        end else if (ri_over) begin
          issued_nxt = 1'b0;
          state_nxt  = T_F2B;
        end else begin
          cmd.start = !issued_r;
        end
      end
      T_F2B: begin
        cmd.start = !issued_r;
        cmd.op    = OP_BLOCK;
        if (run_done) begin
          state_nxt = T_F3;
        end
      end
      T_F3: begin
        if (cnt_r == lanes) begin
          issued_nxt = 1'b0;
          state_nxt  = T_F4;
        end else begin
          cmd.start = !issued_r;
          if (run_done) begin
            cnt_nxt = LANE_AW'(cnt_r + 1'b1);
          end
        end
      end
      T_F4: begin
        cmd.start = !issued_r;
        cmd.op    = OP_BLOCK;
        if (run_done) begin
          state_nxt = T_F5;
        end
      end
      T_F5: begin
        cmd.start = !issued_r;
        cmd.op    = OP_MIX;
        bi_nxt    = 9'd0;
        word_nxt  = 64'h0;
        inword_nxt = 4'd0;
        if (run_done) begin
          state_nxt = T_SQN;
        end
      end
      T_SQN: begin
        cmd.start = !issued_r;
        if (run_done) begin
          state_nxt = T_SQX;
        end
      end
      T_SQX: begin
        cmd.start = !issued_r;
        cmd.op    = OP_XOR;
        if (run_done) begin
          word_nxt   = word_r | (64'(stat.xor_byte) << {(3'd7 - inword_r[2:0]), 3'b000});
          inword_nxt = inword_r + 4'd1;
          bi_nxt     = bi_r + 9'd1;
          state_nxt  = T_SQE;
        end
      end
      T_SQE: begin
        if (!full) begin
          state_nxt = T_SQC;
        end else if (slot_free) begin
          ov_nxt     = 1'b1;
          ow_nxt     = word_r;
          oc_nxt     = inword_r;
          of_nxt     = (bi_r == eff);
          word_nxt   = 64'h0;
          inword_nxt = 4'd0;
          state_nxt  = T_SQC;
        end
      end
      T_SQC: begin
        if (ri_over) begin
          state_nxt = T_SQB;
        end else begin
          state_nxt = (bi_r == eff) ? T_CLR : T_SQN;
        end
      end
      T_SQB: begin
        cmd.start = !issued_r;
        cmd.op    = OP_BLOCK;
        if (run_done) begin
          state_nxt = (bi_r == eff) ? T_CLR : T_SQN;
        end
      end
      T_CLR: begin
        cmd.start = !issued_r;
        cmd.op    = OP_CLEAR;
        if (run_done) begin
          mb_nxt    = '0;
          wb_nxt    = 64'h0;
          bb_nxt    = 4'd0;
          last_nxt  = 1'b0;
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= T_CLR;
      issued_r <= 1'b0;
      hb_r     <= 9'd32;
      mb_r     <= '0;
      wb_r     <= 64'h0;
      bb_r     <= 4'd0;
      last_r   <= 1'b0;
      cnt_r    <= '0;
      bi_r     <= 9'd0;
      inword_r <= 4'd0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      hb_r     <= hb_nxt;
      mb_r     <= mb_nxt;
      wb_r     <= wb_nxt;
      bb_r     <= bb_nxt;
      last_r   <= last_nxt;
      cnt_r    <= cnt_nxt;
      bi_r     <= bi_nxt;
      inword_r <= inword_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= rdata_nxt;
    word_r  <= word_nxt;
    ow_r    <= ow_nxt;
    oc_r    <= oc_nxt;
    of_r    <= of_nxt;
  end

  assign in_ch.ready       = (state_r == T_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = ov_r;
  assign out_ch.hash_word  = ow_r;
  assign out_ch.byte_count = oc_r;
  assign out_ch.final_word = of_r;

endmodule
